// ===== rtl/ecbu_pkg.sv =====
// Shared types, constants and tables for the camera basis update block.
// Holds the microcode program, the CORDIC arctangent table and the field layout.
// No dependencies.
package ecbu_pkg;

    localparam int ANGLE_FRAC_DEF  = 16;
    localparam int VECTOR_FRAC_DEF = 14;

    localparam int DELTA_W   = 12;
    localparam int SENS_W    = 16;
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 1;
    localparam int COMP_W    = 16;
    localparam int YAW_OUT_W = 25;
    localparam int PIT_OUT_W = 24;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 184;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIMIT = 1'b1;
    localparam logic [SENS_W-1:0]    SENS_RST        = 16'd5898;

    // CORDIC: angles in degrees with 24 fractional bits, x/y in Q30
    localparam int CORDIC_STEPS = 24;
    localparam int CNT_W        = 5;
    localparam int ZB           = 24;
    localparam int ZW           = 34;
    localparam int XW           = 33;
    localparam int TRIG_W       = 32;
    localparam int ATAN_W       = 30;
    localparam logic signed [XW-1:0] CORDIC_X0 = 33'sd652032874;

    function automatic logic [ATAN_W-1:0] atan_deg(input logic [CNT_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:  v = 30'd754974720;
            5'd1:  v = 30'd445687602;
            5'd2:  v = 30'd235489088;
            5'd3:  v = 30'd119537938;
            5'd4:  v = 30'd60000934;
            5'd5:  v = 30'd30029717;
            5'd6:  v = 30'd15018523;
            5'd7:  v = 30'd7509720;
            5'd8:  v = 30'd3754917;
            5'd9:  v = 30'd1877466;
            5'd10: v = 30'd938734;
            5'd11: v = 30'd469367;
            5'd12: v = 30'd234684;
            5'd13: v = 30'd117342;
            5'd14: v = 30'd58671;
            5'd15: v = 30'd29335;
            5'd16: v = 30'd14668;
            5'd17: v = 30'd7334;
            5'd18: v = 30'd3667;
            5'd19: v = 30'd1833;
            5'd20: v = 30'd917;
            5'd21: v = 30'd458;
            5'd22: v = 30'd229;
            5'd23: v = 30'd115;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_LOOP,
        SEQ_WAIT_OUT,
        SEQ_RESTART
    } t_seq_op;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DX,
        MUL_DY,
        MUL_CYCP,
        MUL_SYCP,
        MUL_CYSP,
        MUL_SYSP
    } t_mul_sel;

    typedef enum logic [1:0] {
        ALU_NOP,
        ALU_YADD,
        ALU_MOD,
        ALU_YSET
    } t_alu_op;

    typedef enum logic [2:0] {
        RND_NONE,
        RND_FWD_X,
        RND_FWD_Z,
        RND_UP_X,
        RND_UP_Z
    } t_rnd_dst;

    typedef struct packed {
        t_seq_op    seq;
        t_mul_sel   mul;
        t_alu_op    alu;
        logic [1:0] mod_k;
        logic       pitch_upd;
        logic       cordic_load;
        logic       cordic_run;
        logic       trig_store;
        logic       q30_store;
        t_rnd_dst   rnd;
    } t_ucode;

    typedef struct packed {
        logic in_valid;
        logic cordic_last;
        logic out_free;
    } t_cond;

    typedef struct packed {
        logic in_ready;
        logic out_load;
    } t_seq_hs;

    typedef struct packed {
        logic [COMP_W-1:0]    fwd_x;
        logic [COMP_W-1:0]    fwd_y;
        logic [COMP_W-1:0]    fwd_z;
        logic [COMP_W-1:0]    right_x;
        logic [COMP_W-1:0]    right_z;
        logic [COMP_W-1:0]    up_x;
        logic [COMP_W-1:0]    up_y;
        logic [COMP_W-1:0]    up_z;
        logic [YAW_OUT_W-1:0] yaw_out;
        logic [PIT_OUT_W-1:0] pitch_out;
    } t_result;

    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] UPC_WAIT_IN  = 5'd0;
    localparam logic [UPC_W-1:0] UPC_MUL_DX   = 5'd1;
    localparam logic [UPC_W-1:0] UPC_YAW_ADD  = 5'd2;
    localparam logic [UPC_W-1:0] UPC_MOD8     = 5'd3;
    localparam logic [UPC_W-1:0] UPC_MOD4     = 5'd4;
    localparam logic [UPC_W-1:0] UPC_MOD2     = 5'd5;
    localparam logic [UPC_W-1:0] UPC_MOD1     = 5'd6;
    localparam logic [UPC_W-1:0] UPC_YAW_SET  = 5'd7;
    localparam logic [UPC_W-1:0] UPC_CORD_LD  = 5'd8;
    localparam logic [UPC_W-1:0] UPC_CORD_RUN = 5'd9;
    localparam logic [UPC_W-1:0] UPC_TRIG     = 5'd10;
    localparam logic [UPC_W-1:0] UPC_PROD0    = 5'd11;
    localparam logic [UPC_W-1:0] UPC_PROD1    = 5'd12;
    localparam logic [UPC_W-1:0] UPC_PROD2    = 5'd13;
    localparam logic [UPC_W-1:0] UPC_PROD3    = 5'd14;
    localparam logic [UPC_W-1:0] UPC_RND_LAST = 5'd15;
    localparam logic [UPC_W-1:0] UPC_WAIT_OUT = 5'd16;

    localparam t_ucode UC_NOP = '{
        seq: SEQ_NEXT, mul: MUL_NONE, alu: ALU_NOP, mod_k: 2'd0,
        pitch_upd: 1'b0, cordic_load: 1'b0, cordic_run: 1'b0,
        trig_store: 1'b0, q30_store: 1'b0, rnd: RND_NONE
    };

    // Control store: one word per step
    function automatic t_ucode ucode(input logic [UPC_W-1:0] pc);
        t_ucode w;
        w = UC_NOP;
        unique case (pc)
            UPC_WAIT_IN:  w.seq = SEQ_WAIT_IN;
            UPC_MUL_DX:   w.mul = MUL_DX;
            UPC_YAW_ADD: begin
                w.alu = ALU_YADD;
                w.mul = MUL_DY;
            end
            UPC_MOD8: begin
                w.alu       = ALU_MOD;
                w.mod_k     = 2'd3;
                w.pitch_upd = 1'b1;
            end
            UPC_MOD4: begin
                w.alu   = ALU_MOD;
                w.mod_k = 2'd2;
            end
            UPC_MOD2: begin
                w.alu   = ALU_MOD;
                w.mod_k = 2'd1;
            end
            UPC_MOD1: begin
                w.alu   = ALU_MOD;
                w.mod_k = 2'd0;
            end
            UPC_YAW_SET:  w.alu = ALU_YSET;
            UPC_CORD_LD:  w.cordic_load = 1'b1;
            UPC_CORD_RUN: begin
                w.seq        = SEQ_LOOP;
                w.cordic_run = 1'b1;
            end
            UPC_TRIG:     w.trig_store = 1'b1;
            UPC_PROD0: begin
                w.mul       = MUL_CYCP;
                w.q30_store = 1'b1;
            end
            UPC_PROD1: begin
                w.mul = MUL_SYCP;
                w.rnd = RND_FWD_X;
            end
            UPC_PROD2: begin
                w.mul = MUL_CYSP;
                w.rnd = RND_FWD_Z;
            end
            UPC_PROD3: begin
                w.mul = MUL_SYSP;
                w.rnd = RND_UP_X;
            end
            UPC_RND_LAST: w.rnd = RND_UP_Z;
            UPC_WAIT_OUT: w.seq = SEQ_WAIT_OUT;
            default:      w.seq = SEQ_RESTART;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/ecbu_seq.sv =====
// Microcode sequencer: step counter over the control store in ecbu_pkg.
// Issues one control word per cycle and handles waits and the CORDIC loop.
module ecbu_seq
    import ecbu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cond   i_cond,
    output t_ucode  o_ctrl,
    output t_seq_hs o_hs
);

    logic [UPC_W-1:0] r_pc;
    logic [UPC_W-1:0] n_pc;
    t_ucode           w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UPC_WAIT_IN;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        w             = ucode(r_pc);
        o_hs.in_ready = (w.seq == SEQ_WAIT_IN);
        o_hs.out_load = (w.seq == SEQ_WAIT_OUT) && i_cond.out_free;
        n_pc          = r_pc;
        unique case (w.seq)
            SEQ_NEXT:     n_pc = r_pc + 1'b1;
            SEQ_WAIT_IN:  if (i_cond.in_valid) n_pc = r_pc + 1'b1;
            SEQ_LOOP:     if (i_cond.cordic_last) n_pc = r_pc + 1'b1;
            SEQ_WAIT_OUT: if (i_cond.out_free) n_pc = UPC_WAIT_IN;
            SEQ_RESTART:  n_pc = UPC_WAIT_IN;
            default:      n_pc = UPC_WAIT_IN;
        endcase
    end

    assign o_ctrl = w;

endmodule

// ===== rtl/ecbu_cordic.sv =====
// One rotation-mode CORDIC lane, one iteration per cycle while i_run is high, with quadrant fold.
// Depends on ecbu_pkg for the arctangent table and widths.
module ecbu_cordic
    import ecbu_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF,
    parameter int ANGLE_W         = 30
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic                      i_run,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output logic signed [TRIG_W-1:0]  o_cos,
    output logic signed [TRIG_W-1:0]  o_sin,
    output logic                      o_last
);

    localparam int ZS = ZB - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] Z90  = ZW'(longint'(90) <<< ZB);
    localparam logic signed [ZW-1:0] Z180 = ZW'(longint'(180) <<< ZB);
    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);

    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic [CNT_W-1:0]     r_i;
    logic                 r_flip;
    logic signed [ZW-1:0] z_in;
    logic signed [XW-1:0] sx, sy;
    logic signed [ZW-1:0] at;
    logic signed [XW-1:0] c_ext, s_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
        end else if (i_load) begin
            r_i <= '0;
        end else if (i_run) begin
            r_i <= r_i + 1'b1;
        end
    end

    always_comb begin
        z_in = ZW'(i_angle) <<< ZS;
        sx   = r_x >>> r_i;
        sy   = r_y >>> r_i;
        at   = signed'(ZW'(atan_deg(r_i)));
        if (r_z >= 0) begin
            n_x = r_x - sy;
            n_y = r_y + sx;
            n_z = r_z - at;
        end else begin
            n_x = r_x + sy;
            n_y = r_y - sx;
            n_z = r_z + at;
        end
    end

    // Fold the input angle into +/-90 degrees; the result is negated afterwards
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= CORDIC_X0;
            r_y <= '0;
            priority if (z_in > Z90) begin
                r_z    <= z_in - Z180;
                r_flip <= 1'b1;
            end else if (z_in < -Z90) begin
                r_z    <= z_in + Z180;
                r_flip <= 1'b1;
            end else begin
                r_z    <= z_in;
                r_flip <= 1'b0;
            end
        end else if (i_run) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign c_ext  = r_flip ? -r_x : r_x;
    assign s_ext  = r_flip ? -r_y : r_y;
    assign o_cos  = c_ext[TRIG_W-1:0];
    assign o_sin  = s_ext[TRIG_W-1:0];
    assign o_last = (r_i == CORDIC_LAST);

endmodule

// ===== rtl/ecbu_dp.sv =====
// Datapath: configuration registers, angle state, shared multiplier, modulo
// steps, two CORDIC lanes and output rounding. Depends on ecbu_pkg, ecbu_cordic.
module ecbu_dp
    import ecbu_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS  = ANGLE_FRAC_DEF,
    parameter int VECTOR_FRAC_BITS = VECTOR_FRAC_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_ucode                      i_ctrl,
    input  logic                        i_in_fire,
    input  logic signed [DELTA_W-1:0]   i_delta_x,
    input  logic signed [DELTA_W-1:0]   i_delta_y,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,
    output logic                        o_cordic_last,
    output t_result                     o_result
);

    localparam int AW  = (ANGLE_FRAC_BITS + 14 > 26) ? ANGLE_FRAC_BITS + 14 : 26;
    localparam int YW  = ANGLE_FRAC_BITS + 9;
    localparam int PW  = ANGLE_FRAC_BITS + 8;
    localparam int PLW = (ANGLE_FRAC_BITS + 7 > CFG_W) ? ANGLE_FRAC_BITS + 7 : CFG_W;
    localparam int UP  = (ANGLE_FRAC_BITS >= 16) ? ANGLE_FRAC_BITS - 16 : 0;
    localparam int DN  = (ANGLE_FRAC_BITS < 16) ? 16 - ANGLE_FRAC_BITS : 1;
    localparam int RW  = VECTOR_FRAC_BITS + 2;
    localparam int OW  = (RW > COMP_W) ? RW : COMP_W;
    localparam int S30 = 30 - VECTOR_FRAC_BITS;
    localparam int S60 = 60 - VECTOR_FRAC_BITS;

    localparam logic signed [AW-1:0] FULL    = AW'(longint'(360) <<< ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] HALF    = AW'(longint'(180) <<< ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] OFFS    = AW'(longint'(3060) <<< ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] LIM_MAX = AW'(longint'(89) <<< ANGLE_FRAC_BITS);
    localparam logic signed [YW-1:0] YAW_RST = YW'(-(longint'(90) <<< ANGLE_FRAC_BITS));
    localparam logic [PLW-1:0]       PLIM_RST = PLW'(longint'(89) <<< ANGLE_FRAC_BITS);
    localparam logic signed [63:0]   ONE     = 64'sd1 <<< VECTOR_FRAC_BITS;
    localparam logic signed [63:0]   HALF30  = 64'sd1 <<< (S30 - 1);
    localparam logic signed [63:0]   HALF60  = 64'sd1 <<< (S60 - 1);
    localparam logic signed [63:0]   HALFDN  = 64'sd1 <<< (DN - 1);

    logic [SENS_W-1:0]          r_sens;
    logic [PLW-1:0]             r_plim;
    logic signed [YW-1:0]       r_yaw;
    logic signed [PW-1:0]       r_pitch;
    logic signed [DELTA_W-1:0]  r_dx, r_dy;
    logic signed [63:0]         r_prod;
    logic signed [AW-1:0]       r_acc;
    logic signed [TRIG_W-1:0]   r_cy, r_sy, r_cp, r_sp;
    logic [COMP_W-1:0]          r_fwd_x, r_fwd_y, r_fwd_z, r_right_x, r_right_z;
    logic [COMP_W-1:0]          r_up_x, r_up_y, r_up_z;

    logic signed [TRIG_W-1:0]   mul_a, mul_b;
    logic signed [AW-1:0]       sdelta, prod_lo, mod_c, yaw_ext, pitch_ext, p_new, lim;
    logic signed [63:0]         prod_rnd;
    logic signed [AW-1:0]       yaw_set;
    logic signed [TRIG_W-1:0]   cy_l, sy_l, cp_l, sp_l;
    logic                       last_y, last_p;
    logic signed [RW-1:0]       rnd_prod;

    function automatic logic signed [RW-1:0] clamp_unit(input logic signed [63:0] v);
        logic signed [63:0] c;
        priority if (v > ONE) c = ONE;
        else if (v < -ONE)    c = -ONE;
        else                  c = v;
        return c[RW-1:0];
    endfunction

    function automatic logic signed [RW-1:0] rnd30(input logic signed [TRIG_W-1:0] t);
        logic signed [63:0] v;
        v = (64'(t) + HALF30) >>> S30;
        return clamp_unit(v);
    endfunction

    function automatic logic [COMP_W-1:0] to_comp(input logic signed [RW-1:0] v,
                                                  input logic neg);
        logic signed [OW-1:0] e;
        e = OW'(v);
        if (neg) e = -e;
        return e[COMP_W-1:0];
    endfunction

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = r_cy;
        mul_b = r_cp;
        unique case (i_ctrl.mul)
            MUL_DX: begin
                mul_a = TRIG_W'(r_dx);
                mul_b = signed'(TRIG_W'(r_sens));
            end
            MUL_DY: begin
                mul_a = TRIG_W'(r_dy);
                mul_b = signed'(TRIG_W'(r_sens));
            end
            MUL_CYCP: begin
                mul_a = r_cy;
                mul_b = r_cp;
            end
            MUL_SYCP: begin
                mul_a = r_sy;
                mul_b = r_cp;
            end
            MUL_CYSP: begin
                mul_a = r_cy;
                mul_b = r_sp;
            end
            MUL_SYSP: begin
                mul_a = r_sy;
                mul_b = r_sp;
            end
            MUL_NONE: begin
                mul_a = r_cy;
                mul_b = r_cp;
            end
            default: begin
                mul_a = r_cy;
                mul_b = r_cp;
            end
        endcase
    end

    always_comb begin
        // count * sensitivity is Q16 degrees; rescale to the angle format
        prod_lo = r_prod[AW-1:0];
        prod_rnd = (r_prod + HALFDN) >>> DN;
        if (ANGLE_FRAC_BITS >= 16) begin
            sdelta = prod_lo <<< UP;
        end else begin
            sdelta = prod_rnd[AW-1:0];
        end
        yaw_ext   = AW'(r_yaw);
        pitch_ext = AW'(r_pitch);
        mod_c     = FULL <<< i_ctrl.mod_k;
        yaw_set   = r_acc - HALF;
        lim       = signed'(AW'(r_plim));
        if (lim > LIM_MAX) lim = LIM_MAX;
        p_new = pitch_ext - sdelta;
        priority if (p_new > lim) p_new = lim;
        else if (p_new < -lim)    p_new = -lim;
        rnd_prod = clamp_unit((r_prod + HALF60) >>> S60);
    end

    // Architectural state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens  <= SENS_RST;
            r_plim  <= PLIM_RST;
            r_yaw   <= YAW_RST;
            r_pitch <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SENSITIVITY: r_sens <= i_cfg_data[SENS_W-1:0];
                    CFG_PITCH_LIMIT: r_plim <= PLW'(i_cfg_data);
                endcase
            end
            if (i_ctrl.alu == ALU_YSET) r_yaw <= yaw_set[YW-1:0];
            if (i_ctrl.pitch_upd) r_pitch <= p_new[PW-1:0];
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_dx <= i_delta_x;
            r_dy <= i_delta_y;
        end
        if (i_ctrl.mul != MUL_NONE) r_prod <= mul_a * mul_b;
        unique case (i_ctrl.alu)
            ALU_YADD: r_acc <= yaw_ext + sdelta + OFFS;
            ALU_MOD:  if (r_acc >= mod_c) r_acc <= r_acc - mod_c;
            ALU_YSET: r_acc <= r_acc;
            ALU_NOP:  r_acc <= r_acc;
            default:  r_acc <= r_acc;
        endcase
        if (i_ctrl.trig_store) begin
            r_cy <= cy_l;
            r_sy <= sy_l;
            r_cp <= cp_l;
            r_sp <= sp_l;
        end
        if (i_ctrl.q30_store) begin
            r_fwd_y   <= to_comp(rnd30(r_sp), 1'b0);
            r_right_x <= to_comp(rnd30(r_sy), 1'b1);
            r_right_z <= to_comp(rnd30(r_cy), 1'b0);
            r_up_y    <= to_comp(rnd30(r_cp), 1'b0);
        end
        unique case (i_ctrl.rnd)
            RND_FWD_X: r_fwd_x <= to_comp(rnd_prod, 1'b0);
            RND_FWD_Z: r_fwd_z <= to_comp(rnd_prod, 1'b0);
            RND_UP_X:  r_up_x  <= to_comp(rnd_prod, 1'b1);
            RND_UP_Z:  r_up_z  <= to_comp(rnd_prod, 1'b1);
            RND_NONE:  r_fwd_x <= r_fwd_x;
            default:   r_fwd_x <= r_fwd_x;
        endcase
    end

    ecbu_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .ANGLE_W         (AW)
    ) u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_ctrl.cordic_load),
        .i_run   (i_ctrl.cordic_run),
        .i_angle (yaw_ext),
        .o_cos   (cy_l),
        .o_sin   (sy_l),
        .o_last  (last_y)
    );

    ecbu_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .ANGLE_W         (AW)
    ) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_ctrl.cordic_load),
        .i_run   (i_ctrl.cordic_run),
        .i_angle (pitch_ext),
        .o_cos   (cp_l),
        .o_sin   (sp_l),
        .o_last  (last_p)
    );

    // Both lanes load and step together
    assign o_cordic_last = last_y & last_p;

    assign o_result.fwd_x     = r_fwd_x;
    assign o_result.fwd_y     = r_fwd_y;
    assign o_result.fwd_z     = r_fwd_z;
    assign o_result.right_x   = r_right_x;
    assign o_result.right_z   = r_right_z;
    assign o_result.up_x      = r_up_x;
    assign o_result.up_y      = r_up_y;
    assign o_result.up_z      = r_up_z;
    assign o_result.yaw_out   = yaw_ext[YAW_OUT_W-1:0];
    assign o_result.pitch_out = pitch_ext[PIT_OUT_W-1:0];

endmodule

// ===== rtl/euler_camera_basis_update.sv =====
// Top level of the camera basis update: stream ports, configuration port and
// output register. Depends on ecbu_pkg, ecbu_seq and ecbu_dp.
//
// Usage:
//   Input stream (i_s_*) carries one pointer motion item (delta_x, delta_y).
//   Each item updates yaw (wrapped to [-180, 180) degrees) and pitch (clamped
//   to the pitch limit, at most 89 degrees) and yields one result item on the
//   output stream (o_m_*): forward, right and up vectors in Q1.14 and the angles.
//   Configuration writes (i_cfg_*) are always taken; index 0 is sensitivity,
//   index 1 the pitch limit. Write them only while no item is in flight.
// Sequence:
//   One item at a time. The result is loaded into the output register once the
//   sequencer reaches its last step, and the next item is accepted only after
//   that load. The 24-step CORDIC loop, run for yaw and pitch side by side, is
//   the longest part of the work on each item.
// Reset: yaw returns to -90 degrees, pitch to 0, configuration registers to their
//   defaults, and the output stream empties.
// Stall: a finished result waits in the output register; the sequencer holds
//   in its last step until that register is free, and no new item is taken.
module euler_camera_basis_update
    import ecbu_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS  = ANGLE_FRAC_DEF,
    parameter int VECTOR_FRAC_BITS = VECTOR_FRAC_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [11:0] delta_x, [23:12] delta_y
    input  logic [IN_DATA_W-1:0]   i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [15:0] fwd_x, [31:16] fwd_y, [47:32] fwd_z, [63:48] right_x,
    // [79:64] right_z, [95:80] up_x, [111:96] up_y, [127:112] up_z,
    // [152:128] yaw_out, [176:153] pitch_out, [183:177] zero
    output logic [OUT_DATA_W-1:0]  o_m_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    t_cond                 cond;
    t_ucode                ctrl;
    t_seq_hs               hs;
    t_result               res;
    logic                  in_fire;
    logic                  cordic_last;

    assign in_fire          = i_s_tvalid & hs.in_ready;
    assign cond.in_valid    = i_s_tvalid;
    assign cond.cordic_last = cordic_last;
    assign cond.out_free    = !r_out_valid || i_m_tready;

    ecbu_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctrl  (ctrl),
        .o_hs    (hs)
    );

    ecbu_dp #(
        .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
        .VECTOR_FRAC_BITS (VECTOR_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_in_fire     (in_fire),
        .i_delta_x     (signed'(i_s_tdata[11:0])),
        .i_delta_y     (signed'(i_s_tdata[23:12])),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cordic_last (cordic_last),
        .o_result      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (hs.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hs.out_load) begin
            r_out_data <= {7'b0, res.pitch_out, res.yaw_out, res.up_z, res.up_y,
                           res.up_x, res.right_z, res.right_x, res.fwd_z,
                           res.fwd_y, res.fwd_x};
        end
    end

    assign o_s_tready  = hs.in_ready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule
